// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; clock and reset are named clock and reset in every user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CFIR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define CFIR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/cfir_pkg.sv -----
// types and constants of the complex fir filter
// no dependencies; used by the interfaces, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package cfir_pkg;

   // field widths
   localparam int IQ_W          = 16;
   localparam int ACC_W         = 32;
   localparam int COEF_INDEX_W  = 5;
   localparam int TAP_COUNT_W   = 6;
   localparam int SCALE_W       = 5;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 8;

   // request kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_COEF   = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TAP_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_SCALE = 2'd1;

   // register reset values
   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET    = 6'd32;
   localparam logic [SCALE_W-1:0]     OUTPUT_SCALE_RESET = 5'd15;

   typedef logic signed [IQ_W-1:0]  iq_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   typedef struct packed {
      iq_type re;
      iq_type im;
   } cplx_type;

endpackage

`default_nettype wire

// ----- hdl/cfir_if.sv -----
// valid/ready channels of the complex fir filter: request, response, register write
// depends on cfir_pkg
`timescale 1ns / 1ps
`default_nettype none

interface cfir_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   req_type;
   logic signed [cfir_pkg::IQ_W-1:0]       sample_real;
   logic signed [cfir_pkg::IQ_W-1:0]       sample_imag;
   logic        [cfir_pkg::COEF_INDEX_W-1:0] coef_index;
   logic signed [cfir_pkg::IQ_W-1:0]       coef_real;
   logic signed [cfir_pkg::IQ_W-1:0]       coef_imag;

   modport source (output valid, req_type, sample_real, sample_imag, coef_index,
                   coef_real, coef_imag, input ready);
   modport sink   (input valid, req_type, sample_real, sample_imag, coef_index,
                   coef_real, coef_imag, output ready);
endinterface

interface cfir_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [cfir_pkg::IQ_W-1:0] out_real;
   logic signed [cfir_pkg::IQ_W-1:0] out_imag;

   modport source (output valid, out_real, out_imag, input ready);
   modport sink   (input valid, out_real, out_imag, output ready);
endinterface

interface cfir_csr_if;
   logic                                valid;
   logic                                ready;
   logic [cfir_pkg::CSR_INDEX_W-1:0]    wr_index;
   logic [cfir_pkg::CSR_DATA_W-1:0]     wr_data;

   modport source (output valid, wr_index, wr_data, input ready);
   modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

`default_nettype wire

// ----- hdl/complex_fir_filter.sv -----
// complex fir filter: for a sample word, the newest taps history words are multiplied by the coefficients
// (taps = tap_count capped at MAX_TAPS), one mac per tap per cycle, summed, shifted right by scale, registered
// coefficient word: no result, the request side stays ready; after a sample word the next word
// is taken once the result is loaded, later while the previous result is stalled
// synchronous active-high reset: history and taps read as zero, tap_count 32, scale 15
// depends on cfir_pkg and cfir_if
`timescale 1ns / 1ps
`default_nettype none

module complex_fir_filter #(
   parameter int MAX_TAPS = 32
) (
   input  wire         clock,
   input  wire         reset,
   cfir_req_if.sink    req_chan,
   cfir_rsp_if.source  rsp_chan,
   cfir_csr_if.sink    csr_chan
);

   localparam int AW = $clog2(MAX_TAPS);
   localparam int CW = $clog2(MAX_TAPS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   state_type state_ff;

   // configuration
   logic [cfir_pkg::TAP_COUNT_W-1:0] tap_count_ff;
   logic [cfir_pkg::SCALE_W-1:0]     output_scale_ff;

   // control
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [CW-1:0] k_ff, taps_ff, taps_in;
   logic          rd_vld_ff, prod_vld_ff;
   logic          rsp_valid_ff;
   logic          issue, req_accept, sample_accept, coef_we;
   logic [AW-1:0] coef_addr;

   // memories and valid bits
   cfir_pkg::cplx_type history_mem [MAX_TAPS];
   cfir_pkg::cplx_type coef_mem    [MAX_TAPS];
   logic [MAX_TAPS-1:0] hist_vld_ff, coef_vld_ff;

   // datapath
   cfir_pkg::cplx_type hist_rd_ff, coef_rd_ff, x_word, c_word;
   logic               hist_rdv_ff, coef_rdv_ff;
   cfir_pkg::acc_type  p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   cfir_pkg::acc_type  acc_re_ff, acc_im_ff, sh_re, sh_im;
   cfir_pkg::iq_type   out_real_ff, out_imag_ff;

   // handshake decode
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_accept     = req_chan.valid && (state_ff == ST_IDLE);
   assign sample_accept  = req_accept && (req_chan.req_type == cfir_pkg::REQ_SAMPLE);
   assign coef_we        = req_accept && (req_chan.req_type == cfir_pkg::REQ_COEF)
                           && (32'(req_chan.coef_index) < MAX_TAPS);
   assign coef_addr      = AW'(req_chan.coef_index);

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_real = out_real_ff;
   assign rsp_chan.out_imag = out_imag_ff;

   // circular pointer arithmetic and tap cap
   always_comb begin
      head_in    = (head_ff == AW'(MAX_TAPS - 1)) ? '0 : head_ff + AW'(1);
      rd_addr_in = (rd_addr_ff == '0) ? AW'(MAX_TAPS - 1) : rd_addr_ff - AW'(1);
      taps_in    = (32'(tap_count_ff) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(tap_count_ff);
      issue      = (state_ff == ST_RUN) && (k_ff < taps_ff);
      sh_re      = acc_re_ff >>> output_scale_ff;
      sh_im      = acc_im_ff >>> output_scale_ff;
   end

   // state machine, configuration and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         tap_count_ff    <= cfir_pkg::TAP_COUNT_RESET;
         output_scale_ff <= cfir_pkg::OUTPUT_SCALE_RESET;
         head_ff         <= '0;
         rd_addr_ff      <= '0;
         k_ff            <= '0;
         taps_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            case (csr_chan.wr_index)
               cfir_pkg::CSR_TAP_COUNT:
                  tap_count_ff <= csr_chan.wr_data[cfir_pkg::TAP_COUNT_W-1:0];
               cfir_pkg::CSR_OUTPUT_SCALE:
                  output_scale_ff <= csr_chan.wr_data[cfir_pkg::SCALE_W-1:0];
               default: ;
            endcase
         end
         // a taken response word is dropped unless a new one is loaded this cycle
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (sample_accept) begin
                  head_ff    <= head_in;
                  rd_addr_ff <= head_in;
                  taps_ff    <= taps_in;
                  k_ff       <= '0;
                  state_ff   <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (issue) begin
                  k_ff       <= k_ff + CW'(1);
                  rd_addr_ff <= rd_addr_in;
               end else if (!rd_vld_ff && !prod_vld_ff) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  out_real_ff  <= sh_re[cfir_pkg::IQ_W-1:0];
                  out_imag_ff  <= sh_im[cfir_pkg::IQ_W-1:0];
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // valid bits: entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         coef_vld_ff <= '0;
      end else begin
         if (sample_accept) hist_vld_ff[head_in]   <= 1'b1;
         if (coef_we)       coef_vld_ff[coef_addr] <= 1'b1;
      end
   end

   // history and coefficient memories, registered read
   always_ff @(posedge clock) begin
      if (sample_accept) begin
         history_mem[head_in] <= '{re: req_chan.sample_real, im: req_chan.sample_imag};
      end
      if (coef_we) begin
         coef_mem[coef_addr] <= '{re: req_chan.coef_real, im: req_chan.coef_imag};
      end
      hist_rd_ff  <= history_mem[rd_addr_ff];
      coef_rd_ff  <= coef_mem[k_ff[AW-1:0]];
      hist_rdv_ff <= hist_vld_ff[rd_addr_ff];
      coef_rdv_ff <= coef_vld_ff[k_ff[AW-1:0]];
   end

   assign x_word = hist_rdv_ff ? hist_rd_ff : '0;
   assign c_word = coef_rdv_ff ? coef_rd_ff : '0;

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   // partial products
   always_ff @(posedge clock) begin
      p_rr_ff <= $signed(c_word.re) * $signed(x_word.re);
      p_ii_ff <= $signed(c_word.im) * $signed(x_word.im);
      p_ri_ff <= $signed(c_word.re) * $signed(x_word.im);
      p_ir_ff <= $signed(c_word.im) * $signed(x_word.re);
   end

   // wrapping accumulator, cleared when a sample is taken
   always_ff @(posedge clock) begin
      if (sample_accept) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_re_ff <= acc_re_ff + p_rr_ff - p_ii_ff;
         acc_im_ff <= acc_im_ff + p_ri_ff + p_ir_ff;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/cfir_checker.sv -----
// port-level checks of the complex fir filter, bound to the top level
// depends on cfir_pkg, cfir_if and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cfir_checker (
   input  wire         clock,
   input  wire         reset,
   cfir_req_if.sink    req_chan,
   cfir_rsp_if.source  rsp_chan,
   cfir_csr_if.sink    csr_chan
);

   // a waiting response word holds
   `CFIR_ASSERT(a_rsp_hold, rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(rsp_chan.out_real) && $stable(rsp_chan.out_imag), "response word changed while stalled")

   // no response word right after reset
   `CFIR_ASSERT_ALWAYS(a_rsp_reset, $past(reset) |-> !rsp_chan.valid, "response valid after reset")

   // a sample word closes the request side while it is filtered
   `CFIR_ASSERT(a_sample_busy, req_chan.valid && req_chan.ready && (req_chan.req_type == cfir_pkg::REQ_SAMPLE) |=> !req_chan.ready, "request side open during filtering")

   // a new response only follows a busy phase
   `CFIR_ASSERT(a_rsp_after_busy, $rose(rsp_chan.valid) |-> $past(!req_chan.ready), "response without filtering")

   // register writes are never stalled
   `CFIR_ASSERT(a_csr_ready, csr_chan.ready, "register port not ready")

endmodule

bind complex_fir_filter cfir_checker u_cfir_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan),
   .csr_chan (csr_chan)
);

`default_nettype wire
